// ===== design/gbi_pkg.sv =====
// ----------------------------------------------------------------------------
// gbi_pkg: shared definitions of the grid bilinear interpolator
// Opcodes, register indexes, pipeline depths and the records that pass
// between the top level and its cell locator and arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gbi_pkg;

    // Grid geometry: 64 rows by 64 columns, coordinate index of 6 bits.
    localparam int IDX_W     = 6;
    localparam int MAX_DIM   = 64;
    localparam int BANK_AW   = IDX_W - 1;
    localparam int SAMPLE_AW = 2 * BANK_AW;

    // Pipeline depths.
    localparam int CELL_LAT  = 8;
    localparam int DIV_STEPS = 33;
    localparam int ARITH_LAT = 11 + DIV_STEPS;

    // Item opcodes carried on s_tuser.
    localparam logic [1:0] OP_QUERY  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_ROW    = 2'd2;
    localparam logic [1:0] OP_COL    = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_GRID_ROWS   = 3'd0;
    localparam logic [2:0] CFG_GRID_COLS   = 3'd1;
    localparam logic [2:0] CFG_SPACING_1ST = 3'd2;
    localparam logic [2:0] CFG_SPACING_2ND = 3'd3;
    localparam logic [2:0] CFG_EDGE_MODE   = 3'd4;
    localparam logic [2:0] CFG_FILL_RESULT = 3'd5;

    // One input beat as it travels down the front of the pipeline.
    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
        logic [31:0]      write_value;
        logic [31:0]      point_first;
        logic [31:0]      point_second;
    } item_t;

    // Cell index along one axis with its out-of-grid flags.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             below;
        logic             above;
    } cell_t;

    // Corner coordinates, corner samples and the query point, all two's complement.
    typedef struct packed {
        logic [31:0] x0;
        logic [31:0] x1;
        logic [31:0] y0;
        logic [31:0] y1;
        logic [31:0] f00;
        logic [31:0] f01;
        logic [31:0] f10;
        logic [31:0] f11;
        logic [31:0] pt_first;
        logic [31:0] pt_second;
    } corner_t;

    // Interpolated value and its fault flag.
    typedef struct packed {
        logic [31:0] value;
        logic        fault;
    } result_t;

endpackage

`default_nettype wire

// ===== design/gbi_ram.sv =====
// ----------------------------------------------------------------------------
// gbi_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/gbi_cell.sv =====
// ----------------------------------------------------------------------------
// gbi_cell: cell locator along one grid axis
// Floor-divides the point's offset by the spacing one quotient bit per stage
// and flags offsets that fall before the first or past the last cell.
// ----------------------------------------------------------------------------
`default_nettype none

module gbi_cell (
    input  wire logic           aclk,
    input  wire logic           en,
    input  wire logic [32:0]    diff,     // signed offset from the first coordinate
    input  wire logic [30:0]    spacing,  // nonzero spacing
    input  wire logic [6:0]     size,     // grid size in use, 2 to 64
    output gbi_pkg::cell_t      cell_out
);

    localparam int QW = gbi_pkg::IDX_W;

    logic          below_reg [0:QW];
    logic          big_reg   [0:QW];
    logic [30:0]   rem_reg   [0:QW];
    logic [QW-1:0] quo_reg   [0:QW];
    logic [QW-1:0] bits_reg  [0:QW];
    gbi_pkg::cell_t cell_reg;

    logic [32:0] mag;
    logic        big_next;

    // A negative offset counts as zero; the below flag takes care of it.
    assign mag      = diff[32] ? 33'd0 : diff;
    // A quotient of 64 or more cannot be a valid cell.
    assign big_next = {4'd0, mag[32:QW]} >= spacing;

    always_ff @(posedge aclk) begin
        if (en) begin
            below_reg[0] <= diff[32];
            big_reg[0]   <= big_next;
            rem_reg[0]   <= big_next ? 31'd0 : {4'd0, mag[32:QW]};
            quo_reg[0]   <= '0;
            bits_reg[0]  <= mag[QW-1:0];
        end
    end

    // One restoring division step per stage, most significant bit first.
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [31:0] trial;
        logic [31:0] diff_t;
        logic        fits;

        assign trial  = {rem_reg[k], bits_reg[k][QW-1-k]};
        assign diff_t = trial - {1'b0, spacing};
        assign fits   = trial >= {1'b0, spacing};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]   <= fits ? diff_t[30:0] : trial[30:0];
                quo_reg[k+1]   <= {quo_reg[k][QW-2:0], fits};
                bits_reg[k+1]  <= bits_reg[k];
                below_reg[k+1] <= below_reg[k];
                big_reg[k+1]   <= big_reg[k];
            end
        end
    end

    // The upper neighbor must stay inside the grid.
    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg.idx   <= quo_reg[QW];
            cell_reg.below <= below_reg[QW];
            cell_reg.above <= big_reg[QW] || ({1'b0, quo_reg[QW]} >= (size - 7'd1));
        end
    end

    assign cell_out = cell_reg;

endmodule

`default_nettype wire

// ===== design/gbi_arith.sv =====
// ----------------------------------------------------------------------------
// gbi_arith: bilinear blend and rounding divider
// Forms the four area-weighted corner terms exactly, sums them, and divides
// by the cell area with a 33-stage restoring divider, rounding to nearest.
// ----------------------------------------------------------------------------
`default_nettype none

module gbi_arith (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire gbi_pkg::corner_t cin,
    output gbi_pkg::result_t     res
);

    localparam int NS = gbi_pkg::DIV_STEPS;

    typedef struct packed {
        logic [63:0]   rem;
        logic [NS-1:0] quo;
        logic [NS-1:0] bits;
        logic [63:0]   den;
        logic          ovf;
        logic          res_neg;
        logic          num_neg;
        logic          zden;
        logic          nz;
    } div_t;

    function automatic logic [32:0] sx(input logic [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic [31:0] abs33(input logic [32:0] v);
        logic [32:0] n;
        n = v[32] ? (~v + 33'd1) : v;
        return n[31:0];
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // Stage 1: coordinate differences.
    logic [32:0] ax1_reg, ax0_reg, by1_reg, by0_reg, dx_reg, dy_reg;
    logic [31:0] f1_reg [0:3];

    always_ff @(posedge aclk) begin
        if (en) begin
            ax1_reg   <= sx(cin.x1) - sx(cin.pt_first);
            ax0_reg   <= sx(cin.pt_first) - sx(cin.x0);
            by1_reg   <= sx(cin.y1) - sx(cin.pt_second);
            by0_reg   <= sx(cin.pt_second) - sx(cin.y0);
            dx_reg    <= sx(cin.x1) - sx(cin.x0);
            dy_reg    <= sx(cin.y1) - sx(cin.y0);
            f1_reg[0] <= cin.f00;
            f1_reg[1] <= cin.f01;
            f1_reg[2] <= cin.f10;
            f1_reg[3] <= cin.f11;
        end
    end

    // Stage 2: magnitudes and the sign of each term.
    logic [31:0] ma_reg [0:3];
    logic [31:0] mb_reg [0:3];
    logic [31:0] mf2_reg [0:3];
    logic [3:0]  tneg2_reg;
    logic [31:0] mdx_reg, mdy_reg;
    logic        sd2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg[0] <= abs33(ax1_reg);
            ma_reg[1] <= abs33(ax1_reg);
            ma_reg[2] <= abs33(ax0_reg);
            ma_reg[3] <= abs33(ax0_reg);
            mb_reg[0] <= abs33(by1_reg);
            mb_reg[1] <= abs33(by0_reg);
            mb_reg[2] <= abs33(by1_reg);
            mb_reg[3] <= abs33(by0_reg);
            for (int k = 0; k < 4; k++) begin
                mf2_reg[k] <= abs32(f1_reg[k]);
            end
            tneg2_reg[0] <= ax1_reg[32] ^ by1_reg[32] ^ f1_reg[0][31];
            tneg2_reg[1] <= ax1_reg[32] ^ by0_reg[32] ^ f1_reg[1][31];
            tneg2_reg[2] <= ax0_reg[32] ^ by1_reg[32] ^ f1_reg[2][31];
            tneg2_reg[3] <= ax0_reg[32] ^ by0_reg[32] ^ f1_reg[3][31];
            mdx_reg      <= abs33(dx_reg);
            mdy_reg      <= abs33(dy_reg);
            sd2_reg      <= dx_reg[32] ^ dy_reg[32];
        end
    end

    // Stage 3: area weights and cell area.
    logic [63:0] wab_reg [0:3];
    logic [31:0] mf3_reg [0:3];
    logic [3:0]  tneg3_reg;
    logic [63:0] den3_reg;
    logic        sd3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                wab_reg[k] <= ma_reg[k] * mb_reg[k];
                mf3_reg[k] <= mf2_reg[k];
            end
            tneg3_reg <= tneg2_reg;
            den3_reg  <= mdx_reg * mdy_reg;
            sd3_reg   <= sd2_reg;
        end
    end

    // Stage 4: weight times sample as two 32 by 32 partial products.
    logic [63:0] wlo_reg [0:3];
    logic [63:0] whi_reg [0:3];
    logic [3:0]  tneg4_reg;
    logic [63:0] den4_reg;
    logic        sd4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                wlo_reg[k] <= wab_reg[k][31:0] * mf3_reg[k];
                whi_reg[k] <= wab_reg[k][63:32] * mf3_reg[k];
            end
            tneg4_reg <= tneg3_reg;
            den4_reg  <= den3_reg;
            sd4_reg   <= sd3_reg;
        end
    end

    // Stage 5: join the partial products.
    logic [95:0] w_reg [0:3];
    logic [3:0]  tneg5_reg;
    logic [63:0] den5_reg;
    logic        sd5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                w_reg[k] <= {whi_reg[k], 32'd0} + {32'd0, wlo_reg[k]};
            end
            tneg5_reg <= tneg4_reg;
            den5_reg  <= den4_reg;
            sd5_reg   <= sd4_reg;
        end
    end

    // Stage 6: apply the term signs.
    logic [98:0] t_reg [0:3];
    logic [63:0] den6_reg;
    logic        sd6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                t_reg[k] <= tneg5_reg[k] ? (~{3'd0, w_reg[k]} + 99'd1) : {3'd0, w_reg[k]};
            end
            den6_reg <= den5_reg;
            sd6_reg  <= sd5_reg;
        end
    end

    // Stages 7 and 8: sum the four terms.
    logic [98:0] s0_reg, s1_reg, sum_reg;
    logic [63:0] den7_reg, den8_reg;
    logic        sd7_reg, sd8_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_reg   <= t_reg[0] + t_reg[1];
            s1_reg   <= t_reg[2] + t_reg[3];
            den7_reg <= den6_reg;
            sd7_reg  <= sd6_reg;
            sum_reg  <= s0_reg + s1_reg;
            den8_reg <= den7_reg;
            sd8_reg  <= sd7_reg;
        end
    end

    // Stage 9: numerator magnitude and the result sign.
    logic [98:0] nabs;
    logic [97:0] num_reg;
    logic [63:0] den9_reg;
    logic        num_neg_reg, res_neg_reg, nz_reg;

    assign nabs = sum_reg[98] ? (~sum_reg + 99'd1) : sum_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg     <= nabs[97:0];
            num_neg_reg <= sum_reg[98];
            res_neg_reg <= sum_reg[98] ^ sd8_reg;
            nz_reg      <= sum_reg != 99'd0;
            den9_reg    <= den8_reg;
        end
    end

    // Stage 10: a quotient beyond 33 bits always saturates.
    div_t div_reg [0:NS];
    logic ovf_next;

    assign ovf_next = num_reg[97:NS] >= {1'b0, den9_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg[0].rem     <= ovf_next ? 64'd0 : num_reg[96:NS];
            div_reg[0].quo     <= '0;
            div_reg[0].bits    <= num_reg[NS-1:0];
            div_reg[0].den     <= den9_reg;
            div_reg[0].ovf     <= ovf_next;
            div_reg[0].res_neg <= res_neg_reg;
            div_reg[0].num_neg <= num_neg_reg;
            div_reg[0].zden    <= den9_reg == 64'd0;
            div_reg[0].nz      <= nz_reg;
        end
    end

    // Restoring divider, one quotient bit per stage.
    for (genvar k = 0; k < NS; k++) begin : g_div
        logic [64:0] trial;
        logic [64:0] diff_t;
        logic        fits;
        div_t        nxt;

        assign trial  = {div_reg[k].rem, div_reg[k].bits[NS-1-k]};
        assign diff_t = trial - {1'b0, div_reg[k].den};
        assign fits   = trial >= {1'b0, div_reg[k].den};

        always_comb begin
            nxt     = div_reg[k];
            nxt.rem = fits ? diff_t[63:0] : trial[63:0];
            nxt.quo = {div_reg[k].quo[NS-2:0], fits};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                div_reg[k+1] <= nxt;
            end
        end
    end

    // Rounding, saturation and the zero-area case.
    div_t             dv;
    logic             up;
    logic [NS:0]      qr;
    logic [NS:0]      limit;
    logic             sat;
    gbi_pkg::result_t res_next;
    gbi_pkg::result_t res_reg;

    assign dv    = div_reg[NS];
    assign up    = {dv.rem, 1'b0} >= {1'b0, dv.den};
    assign qr    = {1'b0, dv.quo} + {{NS{1'b0}}, up};
    assign limit = dv.res_neg ? 34'h0_8000_0000 : 34'h0_7FFF_FFFF;
    assign sat   = dv.ovf || (qr > limit);

    always_comb begin
        if (dv.zden) begin
            res_next.fault = 1'b1;
            if (!dv.nz) begin
                res_next.value = 32'd0;
            end else begin
                res_next.value = dv.num_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
        end else if (sat) begin
            res_next.fault = 1'b1;
            res_next.value = dv.res_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            res_next.fault = 1'b0;
            res_next.value = dv.res_neg ? (~qr[31:0] + 32'd1) : qr[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== design/grid_bilinear_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// grid_bilinear_interpolator_core: Q16.16 bilinear interpolation on a grid
// Streams write beats into the sample and coordinate stores and answers query
// beats with the interpolated value, the fill value, or a saturated result.
// ----------------------------------------------------------------------------
// The block takes one beat per clock and is fully pipelined: query beats
// yield results in order, and write beats produce no result. Sample, row and
// column stores are synchronous RAMs split in banks by row and column parity,
// so the four corners and both coordinate pairs are read in the same cycle;
// writes reach the stores at the same pipeline stage where queries read them,
// which keeps every beat in order. The cell search is a 6-stage divider per
// axis and the final division a 33-stage divider. When m_tready is low with a
// result waiting, the whole pipeline holds and s_tready drops in the same cycle.
`default_nettype none

module grid_bilinear_interpolator_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Configuration writes
    input  wire logic         cfg_wen,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_wdata,
    // Input beats
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [5:0] row_index, [11:6] col_index, [43:12] write_value,
    // [75:44] point_first, [107:76] point_second
    input  wire logic [111:0] s_tdata,
    // [1:0] opcode
    input  wire logic [1:0]   s_tuser,
    // Result beats
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] interp_value
    output logic [31:0]       m_tdata,
    // [0] used_fill, [1] arith_fault
    output logic [1:0]        m_tuser
);

    localparam int FL = gbi_pkg::CELL_LAT;
    localparam int AL = gbi_pkg::ARITH_LAT;
    localparam int BW = gbi_pkg::BANK_AW;
    localparam int IW = gbi_pkg::IDX_W;

    typedef struct packed {
        logic valid;
        logic fill;
    } tag_t;

    // Configuration registers.
    logic [6:0]  grid_rows_reg, grid_cols_reg;
    logic [30:0] spacing_first_reg, spacing_second_reg;
    logic        edge_mode_reg;
    logic [31:0] fill_result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg      <= 7'd64;
            grid_cols_reg      <= 7'd64;
            spacing_first_reg  <= 31'd65536;
            spacing_second_reg <= 31'd65536;
            edge_mode_reg      <= 1'b0;
            fill_result_reg    <= 32'd0;
        end else if (cfg_wen) begin
            case (cfg_index)
                gbi_pkg::CFG_GRID_ROWS:   grid_rows_reg      <= cfg_wdata[6:0];
                gbi_pkg::CFG_GRID_COLS:   grid_cols_reg      <= cfg_wdata[6:0];
                gbi_pkg::CFG_SPACING_1ST: spacing_first_reg  <= cfg_wdata[30:0];
                gbi_pkg::CFG_SPACING_2ND: spacing_second_reg <= cfg_wdata[30:0];
                gbi_pkg::CFG_EDGE_MODE:   edge_mode_reg      <= cfg_wdata[0];
                gbi_pkg::CFG_FILL_RESULT: fill_result_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective grid size and spacing.
    logic [6:0]  rows_eff, cols_eff;
    logic [30:0] sp_first_eff, sp_second_eff;

    always_comb begin
        if (grid_rows_reg < 7'd2) begin
            rows_eff = 7'd2;
        end else if (grid_rows_reg > 7'(gbi_pkg::MAX_DIM)) begin
            rows_eff = 7'(gbi_pkg::MAX_DIM);
        end else begin
            rows_eff = grid_rows_reg;
        end
        if (grid_cols_reg < 7'd2) begin
            cols_eff = 7'd2;
        end else if (grid_cols_reg > 7'(gbi_pkg::MAX_DIM)) begin
            cols_eff = 7'(gbi_pkg::MAX_DIM);
        end else begin
            cols_eff = grid_cols_reg;
        end
    end

    assign sp_first_eff  = (spacing_first_reg == 31'd0) ? 31'd1 : spacing_first_reg;
    assign sp_second_eff = (spacing_second_reg == 31'd0) ? 31'd1 : spacing_second_reg;

    // Pipeline advance: the output slot is free or being emptied.
    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // Front pipeline: input register through the memory read stage.
    logic                v_reg  [0:FL+2];
    gbi_pkg::item_t      it_reg [0:FL+2];
    gbi_pkg::item_t      it_in;

    assign it_in.op           = s_tuser;
    assign it_in.row_index    = s_tdata[5:0];
    assign it_in.col_index    = s_tdata[11:6];
    assign it_in.write_value  = s_tdata[43:12];
    assign it_in.point_first  = s_tdata[75:44];
    assign it_in.point_second = s_tdata[107:76];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= FL + 2; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            v_reg[0] <= s_tvalid;
            for (int k = 1; k <= FL + 2; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            it_reg[0] <= it_in;
            for (int k = 1; k <= FL + 2; k++) begin
                it_reg[k] <= it_reg[k-1];
            end
        end
    end

    // Copies of the first row and column coordinates for the offset.
    logic [31:0] r0_reg, c0_reg;

    always_ff @(posedge aclk) begin
        if (adv && v_reg[0]) begin
            if (it_reg[0].op == gbi_pkg::OP_ROW && it_reg[0].row_index == '0) begin
                r0_reg <= it_reg[0].write_value;
            end
            if (it_reg[0].op == gbi_pkg::OP_COL && it_reg[0].col_index == '0) begin
                c0_reg <= it_reg[0].write_value;
            end
        end
    end

    // Cell search along both axes.
    logic [32:0]    diff_first, diff_second;
    gbi_pkg::cell_t cell_first, cell_second;

    assign diff_first  = {it_reg[0].point_first[31], it_reg[0].point_first}
                       - {r0_reg[31], r0_reg};
    assign diff_second = {it_reg[0].point_second[31], it_reg[0].point_second}
                       - {c0_reg[31], c0_reg};

    gbi_cell u_cell_first (
        .aclk     (aclk),
        .en       (adv),
        .diff     (diff_first),
        .spacing  (sp_first_eff),
        .size     (rows_eff),
        .cell_out (cell_first)
    );

    gbi_cell u_cell_second (
        .aclk     (aclk),
        .en       (adv),
        .diff     (diff_second),
        .spacing  (sp_second_eff),
        .size     (cols_eff),
        .cell_out (cell_second)
    );

    // Fill decision and clamping to the edge cell.
    logic          outside;
    logic [6:0]    rows_m2, cols_m2;
    logic [IW-1:0] i_next, j_next;
    logic [IW-1:0] i_reg, j_reg;
    logic          fill9_reg;

    assign outside = cell_first.below || cell_first.above
                  || cell_second.below || cell_second.above;
    assign rows_m2 = rows_eff - 7'd2;
    assign cols_m2 = cols_eff - 7'd2;

    always_comb begin
        if (cell_first.below) begin
            i_next = '0;
        end else if (cell_first.above) begin
            i_next = rows_m2[IW-1:0];
        end else begin
            i_next = cell_first.idx;
        end
        if (cell_second.below) begin
            j_next = '0;
        end else if (cell_second.above) begin
            j_next = cols_m2[IW-1:0];
        end else begin
            j_next = cell_second.idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            i_reg     <= i_next;
            j_reg     <= j_next;
            fill9_reg <= !edge_mode_reg && outside;
        end
    end

    // Store access: writes and reads happen at the same stage.
    gbi_pkg::item_t wit;
    logic           wv;
    logic [IW-1:0]  row_sel [0:1];
    logic [IW-1:0]  col_sel [0:1];
    logic [31:0]    rd_row  [0:1];
    logic [31:0]    rd_col  [0:1];
    logic [31:0]    rd_smp  [0:3];

    assign wit = it_reg[FL+1];
    assign wv  = v_reg[FL+1];

    for (genvar b = 0; b < 2; b++) begin : g_coord
        assign row_sel[b] = (i_reg[0] == 1'(b)) ? i_reg : (i_reg + 6'd1);
        assign col_sel[b] = (j_reg[0] == 1'(b)) ? j_reg : (j_reg + 6'd1);

        gbi_ram #(.WIDTH(32), .DEPTH(gbi_pkg::MAX_DIM / 2)) u_row_ram (
            .aclk  (aclk),
            .we    (adv && wv && wit.op == gbi_pkg::OP_ROW && wit.row_index[0] == 1'(b)),
            .waddr (wit.row_index[IW-1:1]),
            .wdata (wit.write_value),
            .re    (adv),
            .raddr (row_sel[b][IW-1:1]),
            .rdata (rd_row[b])
        );

        gbi_ram #(.WIDTH(32), .DEPTH(gbi_pkg::MAX_DIM / 2)) u_col_ram (
            .aclk  (aclk),
            .we    (adv && wv && wit.op == gbi_pkg::OP_COL && wit.col_index[0] == 1'(b)),
            .waddr (wit.col_index[IW-1:1]),
            .wdata (wit.write_value),
            .re    (adv),
            .raddr (col_sel[b][IW-1:1]),
            .rdata (rd_col[b])
        );
    end

    // Sample banks indexed by {row parity, column parity}.
    for (genvar bk = 0; bk < 4; bk++) begin : g_smp
        localparam int RP = bk / 2;
        localparam int CP = bk % 2;

        gbi_ram #(.WIDTH(32), .DEPTH(gbi_pkg::MAX_DIM * gbi_pkg::MAX_DIM / 4)) u_smp_ram (
            .aclk  (aclk),
            .we    (adv && wv && wit.op == gbi_pkg::OP_SAMPLE
                    && wit.row_index[0] == 1'(RP) && wit.col_index[0] == 1'(CP)),
            .waddr ({wit.row_index[IW-1:1], wit.col_index[IW-1:1]}),
            .wdata (wit.write_value),
            .re    (adv),
            .raddr ({row_sel[RP][IW-1:1], col_sel[CP][IW-1:1]}),
            .rdata (rd_smp[bk])
        );
    end

    // Corner selection one stage later, when the read data is in.
    logic ip_reg, jp_reg, fill10_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ip_reg     <= i_reg[0];
            jp_reg     <= j_reg[0];
            fill10_reg <= fill9_reg;
        end
    end

    gbi_pkg::corner_t corner;
    gbi_pkg::item_t   qit;

    assign qit = it_reg[FL+2];

    always_comb begin
        corner.x0        = ip_reg ? rd_row[1] : rd_row[0];
        corner.x1        = ip_reg ? rd_row[0] : rd_row[1];
        corner.y0        = jp_reg ? rd_col[1] : rd_col[0];
        corner.y1        = jp_reg ? rd_col[0] : rd_col[1];
        corner.f00       = rd_smp[{ip_reg, jp_reg}];
        corner.f01       = rd_smp[{ip_reg, ~jp_reg}];
        corner.f10       = rd_smp[{~ip_reg, jp_reg}];
        corner.f11       = rd_smp[{~ip_reg, ~jp_reg}];
        corner.pt_first  = qit.point_first;
        corner.pt_second = qit.point_second;
    end

    // Blend and divide.
    gbi_pkg::result_t arith_res;

    gbi_arith u_arith (
        .aclk (aclk),
        .en   (adv),
        .cin  (corner),
        .res  (arith_res)
    );

    // Tags that follow each query through the arithmetic pipeline.
    tag_t tag_in;
    tag_t tag_reg [1:AL];

    assign tag_in.valid = v_reg[FL+2] && qit.op == gbi_pkg::OP_QUERY;
    assign tag_in.fill  = fill10_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= AL; k++) begin
                tag_reg[k] <= '0;
            end
        end else if (adv) begin
            tag_reg[1] <= tag_in;
            for (int k = 2; k <= AL; k++) begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    // Output register.
    logic [31:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= tag_reg[AL].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (tag_reg[AL].fill) begin
                m_tdata_reg <= fill_result_reg;
                m_tuser_reg <= 2'b01;
            end else begin
                m_tdata_reg <= arith_res.value;
                m_tuser_reg <= {arith_res.fault, 1'b0};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stream test of grid_bilinear_interpolator_core
// Loads sample and coordinate stores, sends query beats under several register
// settings with random idling on both sides, and checks every result beat
// against a bit-exact interpolation predictor kept inside this file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int  DRAIN_CYCLES = 64;
    localparam int  CYCLE_LIMIT  = 1000000;

    typedef struct {
        logic [31:0] value;
        logic        fill;
        logic        fault;
    } interp_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wen;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic [1:0]   m_tuser;

    grid_bilinear_interpolator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Mirror of the block's registers and stores.
    logic [6:0]         grid_rows_r, grid_cols_r;
    logic [30:0]        spacing1_r, spacing2_r;
    logic               edge_mode_r;
    logic signed [31:0] fill_r;
    longint             row_coord[gbi_pkg::MAX_DIM];
    longint             col_coord[gbi_pkg::MAX_DIM];
    longint             samples[gbi_pkg::MAX_DIM][gbi_pkg::MAX_DIM];
    bit                 row_known[gbi_pkg::MAX_DIM];
    bit                 col_known[gbi_pkg::MAX_DIM];
    bit                 sample_known[gbi_pkg::MAX_DIM][gbi_pkg::MAX_DIM];

    interp_t pending_results[$];
    int      errors;
    int      cycles;
    bit      no_gaps;
    bit      rx_no_gaps;
    bit      hold_go;
    bit      hold_done;
    int      hold_left;
    int      stall_left;

    // Clock and cycle limit.
    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 300;
            m_tready  <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready   <= 1'b1;
            stall_left <= pick_gap(rx_no_gaps);
        end
    end

    // Result checker, sampled away from the active edge.
    always @(negedge aclk) begin
        interp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat value %h flags %b",
                         $time, m_tdata, m_tuser);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.value) begin
                    errors++;
                    $display("%0t: interp_value expected %h actual %h",
                             $time, want.value, m_tdata);
                end
                if (m_tuser[0] !== want.fill) begin
                    errors++;
                    $display("%0t: used_fill expected %b actual %b",
                             $time, want.fill, m_tuser[0]);
                end
                if (m_tuser[1] !== want.fault) begin
                    errors++;
                    $display("%0t: arith_fault expected %b actual %b",
                             $time, want.fault, m_tuser[1]);
                end
            end
        end
    end

    function automatic longint eff_size(input logic [6:0] v);
        if (v < 2) return 2;
        if (v > gbi_pkg::MAX_DIM) return gbi_pkg::MAX_DIM;
        return v;
    endfunction

    function automatic longint eff_spacing(input logic [30:0] v);
        return (v == 0) ? 1 : longint'(v);
    endfunction

    function automatic longint floor_quot(input longint n, input longint d);
        longint qt;
        qt = n / d;
        if ((n % d) != 0 && n < 0) qt--;
        return qt;
    endfunction

    // Cell of a point; in extrapolate mode the cell is clamped to the edge.
    function automatic void find_cell(input longint p, input longint q,
                                      output longint i, output longint j,
                                      output bit outside);
        longint rows, cols;
        rows = eff_size(grid_rows_r);
        cols = eff_size(grid_cols_r);
        i = floor_quot(p - row_coord[0], eff_spacing(spacing1_r));
        j = floor_quot(q - col_coord[0], eff_spacing(spacing2_r));
        outside = 0;
        if (!edge_mode_r) begin
            outside = (i < 0 || i + 1 >= rows || j < 0 || j + 1 >= cols);
        end else begin
            if (i < 0) i = 0;
            if (i + 1 >= rows) i = rows - 2;
            if (j < 0) j = 0;
            if (j + 1 >= cols) j = cols - 2;
        end
    endfunction

    function automatic logic signed [127:0] weighted(input longint a, input longint b,
                                                      input longint f);
        logic signed [127:0] wa, wb, wf;
        wa = a;
        wb = b;
        wf = f;
        return wa * wb * wf;
    endfunction

    // Bit-exact interpolation of one query point.
    function automatic interp_t interpolate(input longint p, input longint q);
        interp_t             res;
        longint              i, j, x0, x1, y0, y1, d1, d2;
        bit                  outside, num_neg, res_neg;
        logic signed [127:0] numer;
        logic [127:0]        mag, den, quo, rem, ad1, ad2, limit;
        find_cell(p, q, i, j, outside);
        res.fill = 0;
        if (outside) begin
            res.value = fill_r;
            res.fill  = 1;
            res.fault = 0;
            return res;
        end
        x0 = row_coord[i];
        x1 = row_coord[i + 1];
        y0 = col_coord[j];
        y1 = col_coord[j + 1];
        numer = weighted(x1 - p, y1 - q, samples[i][j])
              + weighted(x1 - p, q - y0, samples[i][j + 1])
              + weighted(p - x0, y1 - q, samples[i + 1][j])
              + weighted(p - x0, q - y0, samples[i + 1][j + 1]);
        num_neg = numer < 0;
        mag = num_neg ? -numer : numer;
        d1 = x1 - x0;
        d2 = y1 - y0;
        ad1 = (d1 < 0) ? -d1 : d1;
        ad2 = (d2 < 0) ? -d2 : d2;
        den = ad1 * ad2;
        res_neg = num_neg ^ (d1 < 0) ^ (d2 < 0);
        if (den == 0) begin
            // Zero cell area: sign follows the numerator alone.
            res.value = (mag == 0) ? 32'h0 : (num_neg ? 32'h80000000 : 32'h7FFFFFFF);
            res.fault = 1;
            return res;
        end
        quo = mag / den;
        rem = mag % den;
        if (rem * 2 >= den) quo = quo + 1;
        limit = res_neg ? 128'h80000000 : 128'h7FFFFFFF;
        if (quo > limit) begin
            res.value = res_neg ? 32'h80000000 : 32'h7FFFFFFF;
            res.fault = 1;
        end else begin
            res.value = res_neg ? -quo[31:0] : quo[31:0];
            res.fault = 0;
        end
        return res;
    endfunction

    // Updates the mirror for one accepted beat.
    function automatic void accept_beat(input logic [1:0] op, input logic [5:0] ri,
                                        input logic [5:0] ci, input logic [31:0] wv,
                                        input logic [31:0] p, input logic [31:0] q);
        case (op)
            gbi_pkg::OP_SAMPLE: begin
                samples[ri][ci]      = longint'($signed(wv));
                sample_known[ri][ci] = 1;
            end
            gbi_pkg::OP_ROW: begin
                row_coord[ri] = longint'($signed(wv));
                row_known[ri] = 1;
            end
            gbi_pkg::OP_COL: begin
                col_coord[ci] = longint'($signed(wv));
                col_known[ci] = 1;
            end
            default: begin
                pending_results.push_back(interpolate(longint'($signed(p)),
                                                      longint'($signed(q))));
            end
        endcase
    endfunction

    // Sends one beat; valid stays high when the next beat follows at once.
    task automatic send_beat(input logic [1:0] op, input logic [5:0] ri,
                             input logic [5:0] ci, input logic [31:0] wv,
                             input logic [31:0] p, input logic [31:0] q);
        bit rdy;
        int gap;
        s_tdata  <= {4'd0, q, p, wv, ci, ri};
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        accept_beat(op, ri, ci, wv, p, q);
        gap = pick_gap(no_gaps);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stops sending, waits for all results and for writes still in flight.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        case (idx)
            gbi_pkg::CFG_GRID_ROWS:   grid_rows_r = val[6:0];
            gbi_pkg::CFG_GRID_COLS:   grid_cols_r = val[6:0];
            gbi_pkg::CFG_SPACING_1ST: spacing1_r  = val[30:0];
            gbi_pkg::CFG_SPACING_2ND: spacing2_r  = val[30:0];
            gbi_pkg::CFG_EDGE_MODE:   edge_mode_r = val[0];
            gbi_pkg::CFG_FILL_RESULT: fill_r      = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [6:0] rows, input logic [6:0] cols,
                              input logic [30:0] sp1, input logic [30:0] sp2,
                              input logic edge_m, input logic [31:0] fill);
        drain();
        write_reg(gbi_pkg::CFG_GRID_ROWS, 32'(rows));
        write_reg(gbi_pkg::CFG_GRID_COLS, 32'(cols));
        write_reg(gbi_pkg::CFG_SPACING_1ST, 32'(sp1));
        write_reg(gbi_pkg::CFG_SPACING_2ND, 32'(sp2));
        write_reg(gbi_pkg::CFG_EDGE_MODE, 32'(edge_m));
        write_reg(gbi_pkg::CFG_FILL_RESULT, fill);
    endtask

    function automatic logic [31:0] rand_sample;
        int r;
        r = $urandom_range(99);
        if (r < 75) return $urandom_range(2097152) - 1048576;
        if (r < 85) return r[0] ? 32'h7FFFFFFF : 32'h80000000;
        return $urandom;
    endfunction

    // Coordinate value near the regular grid position, or anywhere.
    function automatic logic [31:0] rand_coord(input longint base, input longint sp,
                                               input int k);
        longint v;
        if ($urandom_range(99) < 20) return $urandom;
        v = base + k * sp + $urandom_range(32'(sp / 4));
        return v[31:0];
    endfunction

    // Writes whatever a query at (p, q) would read that is still unknown.
    task automatic prepare_cell(input logic [31:0] p, input logic [31:0] q);
        longint i, j;
        bit     outside;
        int     a, b;
        find_cell(longint'($signed(p)), longint'($signed(q)), i, j, outside);
        if (outside) return;
        for (a = int'(i); a <= int'(i) + 1; a++) begin
            if (!row_known[a])
                send_beat(gbi_pkg::OP_ROW, 6'(a), 6'($urandom),
                          rand_coord(row_coord[0], eff_spacing(spacing1_r), a), $urandom,
                          $urandom);
        end
        for (b = int'(j); b <= int'(j) + 1; b++) begin
            if (!col_known[b])
                send_beat(gbi_pkg::OP_COL, 6'($urandom), 6'(b),
                          rand_coord(col_coord[0], eff_spacing(spacing2_r), b), $urandom,
                          $urandom);
        end
        for (a = int'(i); a <= int'(i) + 1; a++)
            for (b = int'(j); b <= int'(j) + 1; b++)
                if (!sample_known[a][b])
                    send_beat(gbi_pkg::OP_SAMPLE, 6'(a), 6'(b), rand_sample(), $urandom,
                              $urandom);
    endtask

    task automatic query(input logic [31:0] p, input logic [31:0] q);
        prepare_cell(p, q);
        send_beat(gbi_pkg::OP_QUERY, 6'($urandom), 6'($urandom), $urandom, p, q);
    endtask

    // Point mostly within one cell of the grid, sometimes anywhere.
    function automatic logic [31:0] rand_point(input longint base, input longint sp,
                                               input longint size);
        longint v;
        if ($urandom_range(99) < 30) return $urandom;
        v = base + (longint'($urandom_range(32'(size))) - 1) * sp
            + $urandom_range(32'(sp - 1));
        return v[31:0];
    endfunction

    task automatic random_query;
        query(rand_point(row_coord[0], eff_spacing(spacing1_r), eff_size(grid_rows_r)),
              rand_point(col_coord[0], eff_spacing(spacing2_r), eff_size(grid_cols_r)));
    endtask

    task automatic random_items(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(99) < 25)
                send_beat(2'($urandom_range(3, 1)), 6'($urandom), 6'($urandom),
                          rand_sample(), $urandom, $urandom);
            else
                random_query();
        end
    endtask

    // Reset values, grid origin, and plain queries inside and outside.
    task automatic test_reset_grid;
        send_beat(gbi_pkg::OP_ROW, 6'd0, 6'd63, 32'h0, 32'hFFFFFFFF, 32'h0);
        send_beat(gbi_pkg::OP_COL, 6'd63, 6'd0, 32'h0, 32'h0, 32'hFFFFFFFF);
        query(32'h00008000, 32'h00008000);
        query(32'h00010000, 32'h00020000);
        query(32'hFFFF0000, 32'h00008000);
        query(32'h003F0000, 32'h00008000);
        query(32'h7FFFFFFF, 32'h80000000);
    endtask

    // Fill value extremes, saturation and zero cell area on a 2 by 2 grid.
    task automatic test_edge_cases;
        set_config(7'd2, 7'd2, 31'd65536, 31'd65536, 1'b0, 32'h80000000);
        query(32'h80000000, 32'h00000000);
        set_config(7'd2, 7'd2, 31'd65536, 31'd65536, 1'b0, 32'h7FFFFFFF);
        query(32'h00000000, 32'h7FFFFFFF);
        send_beat(gbi_pkg::OP_ROW, 6'd1, 6'd0, 32'h00010000, 32'h0, 32'h0);
        send_beat(gbi_pkg::OP_COL, 6'd0, 6'd1, 32'h00010000, 32'h0, 32'h0);
        send_beat(gbi_pkg::OP_SAMPLE, 6'd0, 6'd0, 32'h7FFFFFFF, 32'h0, 32'h0);
        send_beat(gbi_pkg::OP_SAMPLE, 6'd0, 6'd1, 32'h80000000, 32'h0, 32'h0);
        send_beat(gbi_pkg::OP_SAMPLE, 6'd1, 6'd0, 32'h7FFFFFFF, 32'h0, 32'h0);
        send_beat(gbi_pkg::OP_SAMPLE, 6'd1, 6'd1, 32'h7FFFFFFF, 32'h0, 32'h0);
        query(32'h00000000, 32'h00000000);
        query(32'h00008000, 32'h00004000);
        set_config(7'd2, 7'd2, 31'd65536, 31'd65536, 1'b1, 32'h0);
        // Far outside the grid the weights explode and the result saturates.
        query(32'h7FFFFFFF, 32'h7FFFFFFF);
        query(32'h80000000, 32'h7FFFFFFF);
        // Collapsed rows: zero area, with nonzero and then zero numerator.
        send_beat(gbi_pkg::OP_ROW, 6'd1, 6'd0, 32'h0, 32'h0, 32'h0);
        query(32'h00004000, 32'h00004000);
        send_beat(gbi_pkg::OP_SAMPLE, 6'd1, 6'd0, 32'h80000000, 32'h0, 32'h0);
        send_beat(gbi_pkg::OP_SAMPLE, 6'd0, 6'd0, 32'h80000000, 32'h0, 32'h0);
        send_beat(gbi_pkg::OP_SAMPLE, 6'd1, 6'd1, 32'h80000000, 32'h0, 32'h0);
        query(32'h00004000, 32'h00004000);
        send_beat(gbi_pkg::OP_ROW, 6'd1, 6'd0, 32'h00010000, 32'h0, 32'h0);
    endtask

    // Random traffic under a sweep of register settings.
    task automatic test_config_sweep;
        int ph;
        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_config(7'd64, 7'd64, 31'd65536, 31'd65536, 1'b0, $urandom);
                1: set_config(7'd2, 7'd2, 31'd1, 31'h7FFFFFFF, 1'b1, $urandom);
                2: set_config(7'd0, 7'd127, 31'd0, 31'd0, 1'b0, 32'h7FFFFFFF);
                3: set_config(7'($urandom_range(64, 2)), 7'($urandom_range(64, 2)),
                              31'($urandom_range(1048576, 1)),
                              31'($urandom_range(1048576, 1)),
                              1'b1, $urandom);
                4: set_config(7'd3, 7'd64, 31'h7FFFFFFF, 31'd1, 1'b0, 32'h80000000);
                default: set_config(7'($urandom_range(64, 2)), 7'($urandom_range(64, 2)),
                                    31'($urandom_range(262144, 1)), 31'($urandom),
                                    ph[0], $urandom);
            endcase
            no_gaps    = (ph % 3 == 0);
            rx_no_gaps = (ph % 4 == 1);
            random_items(40);
        end
        no_gaps    = 0;
        rx_no_gaps = 0;
    endtask

    // The receiver holds off while beats keep coming, so the block must stall.
    task automatic test_backpressure;
        set_config(7'd64, 7'd64, 31'd65536, 31'd65536, 1'b1, $urandom);
        no_gaps = 1;
        hold_go = 1;
        random_items(80);
        no_gaps = 0;
    endtask

    // The sender pauses until everything is back, then resumes.
    task automatic test_pause_resume;
        random_items(20);
        drain();
        random_items(20);
    endtask

    initial begin
        aclk        = 0;
        aresetn     = 0;
        cfg_wen     = 0;
        cfg_index   = gbi_pkg::CFG_GRID_ROWS;
        cfg_wdata   = 0;
        s_tvalid    = 0;
        s_tdata     = 0;
        s_tuser     = gbi_pkg::OP_QUERY;
        m_tready    = 0;
        errors      = 0;
        cycles      = 0;
        no_gaps     = 0;
        rx_no_gaps  = 0;
        hold_go     = 0;
        hold_done   = 0;
        hold_left   = 0;
        stall_left  = 0;
        grid_rows_r = 64;
        grid_cols_r = 64;
        spacing1_r  = 65536;
        spacing2_r  = 65536;
        edge_mode_r = 0;
        fill_r      = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_grid();
        test_edge_cases();
        test_config_sweep();
        test_backpressure();
        test_pause_resume();
        drain();

        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
